// ===== sv/rcps_pkg.sv =====
// Shared constants, register codes and stage records of the raycast column pixel shader.
package rcps_pkg;

    // Screen geometry.
    localparam int SCREEN_WIDTH = 1024;
    localparam int MAX_ROWS     = 1024;

    // Field widths.
    localparam int COL_W    = $clog2(SCREEN_WIDTH);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int SPAN_W   = 12;
    localparam int DIST_W   = 16;
    localparam int HEIGHT_W = 11;
    localparam int COLOR_W  = 24;
    localparam int CH_W     = 8;
    localparam int INDEX_W  = 20;
    localparam int CFG_IDX_W = 3;

    // Shading arithmetic: factor is Q0.16 and keep is Q1.16.
    localparam int FRAC_W     = 16;
    localparam int KEEP_W     = FRAC_W + 1;
    localparam int KEEP_ONE   = 1 << FRAC_W;
    localparam int FACTOR_CAP = 58982;
    localparam int KEEP_MIN   = KEEP_ONE - FACTOR_CAP;

    // Wall factor is the raw Q8.8 distance times eight, read as Q0.16.
    localparam int WALL_DIST_SHIFT = 3;
    localparam int WALL_DIST_CAP   =
        (FACTOR_CAP + (1 << WALL_DIST_SHIFT) - 1) / (1 << WALL_DIST_SHIFT);

    // Ground factor is gap * 65536 / 800, done as a reciprocal multiply.
    localparam int    GROUND_DIVISOR     = 800;
    localparam int    GROUND_GAP_CAP     =
        (FACTOR_CAP * GROUND_DIVISOR + KEEP_ONE - 1) / KEEP_ONE;
    localparam int    GAP_W              = $clog2(GROUND_GAP_CAP);
    localparam int    GROUND_RECIP_SHIFT = 15;
    localparam longint GROUND_RECIP      =
        ((longint'(1) << (GROUND_RECIP_SHIFT + FRAC_W)) + GROUND_DIVISOR - 1)
        / GROUND_DIVISOR;
    localparam int    RECIP_W            = 22;
    localparam int    GPROD_W            = GAP_W + RECIP_W;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(768);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WALL_A = 3'd0,
        CFG_WALL_B = 3'd1,
        CFG_WALL_C = 3'd2,
        CFG_WALL_D = 3'd3,
        CFG_SKY    = 3'd4,
        CFG_GROUND = 3'd5,
        CFG_HEIGHT = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [COLOR_W-1:0]  wall_a;
        logic [COLOR_W-1:0]  wall_b;
        logic [COLOR_W-1:0]  wall_c;
        logic [COLOR_W-1:0]  wall_d;
        logic [COLOR_W-1:0]  sky;
        logic [COLOR_W-1:0]  ground;
        logic [HEIGHT_W-1:0] height;
    } rcps_cfg_t;

    // Output of the classify stage.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               sky;
        logic               wall;
        logic [FRAC_W-1:0]  wall_factor;
        logic [GAP_W-1:0]   gap;
        logic               gap_sat;
        logic [INDEX_W-1:0] index;
    } rcps_cls_t;

    // Output of the factor stage.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [KEEP_W-1:0]  keep;
        logic [INDEX_W-1:0] index;
    } rcps_fac_t;

    // Finished pixel.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [INDEX_W-1:0] index;
    } rcps_pix_t;

endpackage

// ===== sv/rcps_if.sv =====
// Valid/ready channel interfaces for pixel items and shaded results.
interface rcps_item_if;
    logic                         valid;
    logic                         ready;
    logic [rcps_pkg::COL_W-1:0]   column;
    logic [rcps_pkg::ROW_W-1:0]   row;
    logic signed [rcps_pkg::SPAN_W-1:0] span_start;
    logic signed [rcps_pkg::SPAN_W-1:0] span_end;
    logic                         step_x_negative;
    logic                         step_y_negative;
    logic                         hit_side_one;
    logic [rcps_pkg::DIST_W-1:0]  wall_distance;

    modport source (
        output valid, column, row, span_start, span_end,
               step_x_negative, step_y_negative, hit_side_one, wall_distance,
        input  ready
    );
    modport sink (
        input  valid, column, row, span_start, span_end,
               step_x_negative, step_y_negative, hit_side_one, wall_distance,
        output ready
    );
endinterface

interface rcps_result_if;
    logic                          valid;
    logic                          ready;
    logic [rcps_pkg::COLOR_W-1:0]  pixel_color;
    logic [rcps_pkg::INDEX_W-1:0]  pixel_index;

    modport source (
        output valid, pixel_color, pixel_index,
        input  ready
    );
    modport sink (
        input  valid, pixel_color, pixel_index,
        output ready
    );
endinterface

// ===== sv/rcps_classify.sv =====
// Stage one: sorts the pixel into sky, wall or ground and picks its base color.
module rcps_classify (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  logic [rcps_pkg::COL_W-1:0]       column,
    input  logic [rcps_pkg::ROW_W-1:0]       row,
    input  logic signed [rcps_pkg::SPAN_W-1:0] span_start,
    input  logic signed [rcps_pkg::SPAN_W-1:0] span_end,
    input  logic                             step_x_negative,
    input  logic                             step_y_negative,
    input  logic                             hit_side_one,
    input  logic [rcps_pkg::DIST_W-1:0]      wall_distance,
    input  rcps_pkg::rcps_cfg_t              cfg,
    output logic                             out_valid,
    output rcps_pkg::rcps_cls_t              out_data
);

    logic                                   valid_reg;
    rcps_pkg::rcps_cls_t                    data_reg;
    rcps_pkg::rcps_cls_t                    data_next;
    logic signed [rcps_pkg::SPAN_W-1:0]     row_s;
    logic [rcps_pkg::HEIGHT_W-1:0]          row_h;
    logic [rcps_pkg::HEIGHT_W-1:0]          diff;
    logic [rcps_pkg::DIST_W+rcps_pkg::WALL_DIST_SHIFT-1:0] dist_scaled;
    logic                                   is_sky;
    logic                                   is_wall;
    logic [rcps_pkg::COLOR_W-1:0]           wall_color;

    always_comb
    begin
        row_s       = $signed(rcps_pkg::SPAN_W'(row));
        row_h       = rcps_pkg::HEIGHT_W'(row);
        is_sky      = row_s < span_start;
        is_wall     = !is_sky && (row_s <= span_end) && (row_h < cfg.height);
        dist_scaled = {wall_distance, {rcps_pkg::WALL_DIST_SHIFT{1'b0}}};
        diff        = (cfg.height >= row_h) ? (cfg.height - row_h) : (row_h - cfg.height);

        if (hit_side_one)
            wall_color = step_y_negative ? cfg.wall_a : cfg.wall_b;
        else
            wall_color = step_x_negative ? cfg.wall_c : cfg.wall_d;

        data_next.sky   = is_sky;
        data_next.wall  = is_wall;
        data_next.color = is_sky ? cfg.sky : (is_wall ? wall_color : cfg.ground);

        if (wall_distance >= rcps_pkg::DIST_W'(rcps_pkg::WALL_DIST_CAP))
            data_next.wall_factor = rcps_pkg::FRAC_W'(rcps_pkg::FACTOR_CAP);
        else
            data_next.wall_factor = dist_scaled[rcps_pkg::FRAC_W-1:0];

        data_next.gap_sat = diff >= rcps_pkg::HEIGHT_W'(rcps_pkg::GROUND_GAP_CAP);
        data_next.gap     = diff[rcps_pkg::GAP_W-1:0];
        data_next.index   = rcps_pkg::INDEX_W'(column)
                          + rcps_pkg::INDEX_W'(row) * rcps_pkg::INDEX_W'(rcps_pkg::SCREEN_WIDTH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/rcps_factor.sv =====
// Stage two: works out the darkening factor and turns it into the keep fraction.
module rcps_factor (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  rcps_pkg::rcps_cls_t in_data,
    output logic                out_valid,
    output rcps_pkg::rcps_fac_t out_data
);

    logic                              valid_reg;
    rcps_pkg::rcps_fac_t               data_reg;
    rcps_pkg::rcps_fac_t               data_next;
    logic [rcps_pkg::GPROD_W-1:0]      gprod;
    logic [rcps_pkg::FRAC_W-1:0]       ground_factor;
    logic [rcps_pkg::FRAC_W-1:0]       factor;

    always_comb
    begin
        // Reciprocal multiply stands in for the divide by 800.
        gprod = rcps_pkg::GPROD_W'(in_data.gap)
              * rcps_pkg::GPROD_W'(rcps_pkg::GROUND_RECIP);
        ground_factor = gprod[rcps_pkg::GROUND_RECIP_SHIFT +: rcps_pkg::FRAC_W];

        if (in_data.sky)
            factor = '0;
        else if (in_data.wall)
            factor = in_data.wall_factor;
        else if (in_data.gap_sat)
            factor = rcps_pkg::FRAC_W'(rcps_pkg::FACTOR_CAP);
        else
            factor = ground_factor;

        data_next.color = in_data.color;
        data_next.index = in_data.index;
        data_next.keep  = rcps_pkg::KEEP_W'(rcps_pkg::KEEP_ONE)
                        - rcps_pkg::KEEP_W'(factor);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/rcps_shade.sv =====
// Stage three: scales each color channel by the keep fraction into the output register.
module rcps_shade (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  rcps_pkg::rcps_fac_t in_data,
    output logic                out_valid,
    output rcps_pkg::rcps_pix_t out_data
);

    localparam int PROD_W = rcps_pkg::CH_W + rcps_pkg::KEEP_W;
    localparam int NUM_CH = rcps_pkg::COLOR_W / rcps_pkg::CH_W;

    logic                valid_reg;
    rcps_pkg::rcps_pix_t data_reg;
    rcps_pkg::rcps_pix_t data_next;
    logic [PROD_W-1:0]   prod [NUM_CH];

    always_comb
    begin
        data_next.index = in_data.index;
        for (int i = 0; i < NUM_CH; i++)
        begin
            prod[i] = PROD_W'(in_data.color[i*rcps_pkg::CH_W +: rcps_pkg::CH_W])
                    * PROD_W'(in_data.keep);
            data_next.color[i*rcps_pkg::CH_W +: rcps_pkg::CH_W] =
                prod[i][rcps_pkg::FRAC_W +: rcps_pkg::CH_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/raycast_column_pixel_shader_unit.sv =====
// Top level of the raycast column pixel shader: register file, pipeline and handshake.
//
// Usage: pixel items arrive on the item channel, one beat per pixel, carrying the row,
// column, wall span, step signs, hit side and Q8.8 wall distance. Each item yields one
// beat on the result channel with the packed RGB color and the frame-buffer index.
// Colors and the screen height are set through the write port (cfg_we, cfg_index,
// cfg_data) while no pixel is in flight; writes take effect at the next clock edge.
//
// An accepted item passes through three pipeline registers: classify and color
// select, shading factor and keep fraction, then the channel multiplies into the
// output register. Throughput is one pixel per clock while the receiver does not
// stall; the registers move together, so a new item is accepted in every cycle the
// result is taken or the output register is empty.
//
// When the receiver stalls while a result waits in the output register, the whole
// pipeline holds in place and item ready drops, so nothing is lost or repeated. While
// the output register is empty, a stalled receiver does not hold up the pipeline.
// Reset clears every valid bit, sets all colors to black and the screen height to 768.
module raycast_column_pixel_shader_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    rcps_item_if.sink                          item,
    rcps_result_if.source                      result,
    input  logic                               cfg_we,
    input  logic [rcps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rcps_pkg::COLOR_W-1:0]       cfg_data
);

    rcps_pkg::rcps_cfg_t cfg_reg;
    logic                en;
    logic                cls_valid;
    rcps_pkg::rcps_cls_t cls;
    logic                fac_valid;
    rcps_pkg::rcps_fac_t fac;
    logic                pix_valid;
    rcps_pkg::rcps_pix_t pix;

    // Register file. Unused index seven is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.wall_a <= '0;
            cfg_reg.wall_b <= '0;
            cfg_reg.wall_c <= '0;
            cfg_reg.wall_d <= '0;
            cfg_reg.sky    <= '0;
            cfg_reg.ground <= '0;
            cfg_reg.height <= rcps_pkg::HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (rcps_pkg::cfg_idx_t'(cfg_index))
                rcps_pkg::CFG_WALL_A: cfg_reg.wall_a <= cfg_data;
                rcps_pkg::CFG_WALL_B: cfg_reg.wall_b <= cfg_data;
                rcps_pkg::CFG_WALL_C: cfg_reg.wall_c <= cfg_data;
                rcps_pkg::CFG_WALL_D: cfg_reg.wall_d <= cfg_data;
                rcps_pkg::CFG_SKY:    cfg_reg.sky    <= cfg_data;
                rcps_pkg::CFG_GROUND: cfg_reg.ground <= cfg_data;
                rcps_pkg::CFG_HEIGHT: cfg_reg.height <= cfg_data[rcps_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline advances whenever the output register is free or being drained.
    assign en         = !pix_valid || result.ready;
    assign item.ready = en;

    rcps_classify u_classify (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (en),
        .in_valid        (item.valid),
        .column          (item.column),
        .row             (item.row),
        .span_start      (item.span_start),
        .span_end        (item.span_end),
        .step_x_negative (item.step_x_negative),
        .step_y_negative (item.step_y_negative),
        .hit_side_one    (item.hit_side_one),
        .wall_distance   (item.wall_distance),
        .cfg             (cfg_reg),
        .out_valid       (cls_valid),
        .out_data        (cls)
    );

    rcps_factor u_factor (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cls_valid),
        .in_data   (cls),
        .out_valid (fac_valid),
        .out_data  (fac)
    );

    rcps_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fac_valid),
        .in_data   (fac),
        .out_valid (pix_valid),
        .out_data  (pix)
    );

    assign result.valid       = pix_valid;
    assign result.pixel_color = pix.color;
    assign result.pixel_index = pix.index;

    // Input is held off only by a full, stalled output register.
    a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !item.ready |-> (result.valid && !result.ready))
        else $error("item ready low without an output stall");

    // An accepted beat lands in the classify stage.
    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (item.valid && item.ready) |=> cls_valid)
        else $error("accepted beat missing from classify stage");

    // The keep fraction never darkens past the cap nor brightens.
    a_keep_range: assert property (@(posedge clk) disable iff (!rst_n)
        fac_valid |-> (fac.keep >= rcps_pkg::KEEP_W'(rcps_pkg::KEEP_MIN)
                       && fac.keep <= rcps_pkg::KEEP_W'(rcps_pkg::KEEP_ONE)))
        else $error("keep fraction out of range");

    // Sky pixels pass through unshaded.
    a_sky_unshaded: assert property (@(posedge clk) disable iff (!rst_n)
        (cls_valid && cls.sky && en) |=> (fac.keep == rcps_pkg::KEEP_W'(rcps_pkg::KEEP_ONE)))
        else $error("sky pixel was shaded");

endmodule

// ===== tb/raycast_column_pixel_shader_unit_test.sv =====
// Self-checking testbench for the raycast column pixel shader unit.
module raycast_column_pixel_shader_unit_test;
    import rcps_pkg::*;

    // Run ends with a failure if it is still going after this many cycles.
    localparam int CYCLE_LIMIT = 200000;

    // Which of the three rules colors a pixel.
    typedef enum int {
        REGION_SKY,
        REGION_WALL,
        REGION_GROUND
    } region_t;

    // How the color registers are loaded for a batch.
    typedef enum int {
        PALETTE_RANDOM,
        PALETTE_HIGH_LOW,
        PALETTE_LOW_HIGH
    } palette_t;

    // One pixel item as it travels on the item channel.
    typedef struct {
        logic [COL_W-1:0]         column;
        logic [ROW_W-1:0]         row;
        logic signed [SPAN_W-1:0] span_start;
        logic signed [SPAN_W-1:0] span_end;
        logic                     step_x_negative;
        logic                     step_y_negative;
        logic                     hit_side_one;
        logic [DIST_W-1:0]        wall_distance;
    } pixel_req_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COLOR_W-1:0]   cfg_data;

    rcps_item_if   item_ch ();
    rcps_result_if result_ch ();

    raycast_column_pixel_shader_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Our own copy of the register file, kept in step with every write we issue.
    rcps_cfg_t palette;

    // Items waiting to be driven, and the pixels we expect back in order.
    pixel_req_t pending_items[$];
    rcps_pix_t  expected_pixels[$];

    // The item currently presented on the channel.
    pixel_req_t on_wire;

    int  src_gap;
    int  sink_stall;
    bit  calm;
    int  mismatches;
    int  items_sent;
    int  pixels_checked;
    int  settings_loaded;
    int  region_count[3];
    int  cycle_count;

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Sky wins first, then the wall span as long as the row is on screen,
    // and everything else (below the span, empty span, off screen) is ground.
    function automatic region_t classify(input pixel_req_t req);
        int row_i;
        int start_i;
        int end_i;
        row_i = req.row;
        start_i = req.span_start;
        end_i = req.span_end;
        if (row_i < start_i)
            return REGION_SKY;
        if (row_i <= end_i && row_i < int'(palette.height))
            return REGION_WALL;
        return REGION_GROUND;
    endfunction

    // Scales each channel by (1 - factor) in Q0.16, with the factor capped at 0.9.
    function automatic logic [COLOR_W-1:0] darken(input logic [COLOR_W-1:0] color,
                                                  input longint factor);
        logic [KEEP_W-1:0] keep;
        logic [31:0]       red_p;
        logic [31:0]       green_p;
        logic [31:0]       blue_p;
        if (factor > FACTOR_CAP)
            factor = FACTOR_CAP;
        keep = KEEP_W'(KEEP_ONE - factor);
        red_p = 32'(color[23:16]) * 32'(keep);
        green_p = 32'(color[15:8]) * 32'(keep);
        blue_p = 32'(color[7:0]) * 32'(keep);
        return {red_p[23:16], green_p[23:16], blue_p[23:16]};
    endfunction

    function automatic rcps_pix_t predict_pixel(input pixel_req_t req);
        rcps_pix_t          pix;
        logic [COLOR_W-1:0] base;
        int                 gap;
        int                 height_i;
        height_i = palette.height;
        case (classify(req))
            REGION_SKY:
            begin
                pix.color = palette.sky;
            end
            REGION_WALL:
            begin
                if (req.hit_side_one)
                    base = req.step_y_negative ? palette.wall_a : palette.wall_b;
                else
                    base = req.step_x_negative ? palette.wall_c : palette.wall_d;
                // Q8.8 distance over 32 is the raw distance times eight in Q0.16.
                pix.color = darken(base, longint'(req.wall_distance) * 8);
            end
            default:
            begin
                // Rows past the screen bottom use the absolute distance to it.
                gap = (height_i >= int'(req.row)) ? height_i - int'(req.row)
                                                  : int'(req.row) - height_i;
                pix.color = darken(palette.ground, (longint'(gap) << 16) / GROUND_DIVISOR);
            end
        endcase
        pix.index = INDEX_W'(int'(req.column) + int'(req.row) * SCREEN_WIDTH);
        return pix;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic pixel_req_t make_req(input int column, input int row,
                                            input int span_start, input int span_end,
                                            input bit step_x_negative,
                                            input bit step_y_negative,
                                            input bit hit_side_one, input int distance);
        pixel_req_t req;
        req.column = COL_W'(column);
        req.row = ROW_W'(row);
        req.span_start = SPAN_W'(span_start);
        req.span_end = SPAN_W'(span_end);
        req.step_x_negative = step_x_negative;
        req.step_y_negative = step_y_negative;
        req.hit_side_one = hit_side_one;
        req.wall_distance = DIST_W'(distance);
        return req;
    endfunction

    // Most items are built around their row so that every region shows up often;
    // one in ten carries a span with fully random bits.
    function automatic pixel_req_t random_pixel();
        int row;
        int rows_on_screen;
        int span_start;
        int span_end;
        int distance;
        int pick;
        rows_on_screen = palette.height;
        if (rows_on_screen > 1024)
            rows_on_screen = 1024;
        if (rows_on_screen > 0 && $urandom_range(0, 4) != 0)
            row = $urandom_range(0, rows_on_screen - 1);
        else
            row = $urandom_range(0, 1023);

        pick = $urandom_range(0, 9);
        if (pick <= 1)
        begin
            span_start = row + 1 + $urandom_range(0, 2046 - row);
            span_end = int'($urandom_range(0, 4095)) - 2048;
        end
        else if (pick <= 5)
        begin
            span_start = int'($urandom_range(0, row + 2048)) - 2048;
            span_end = row + $urandom_range(0, 2047 - row);
        end
        else if (pick <= 7)
        begin
            span_start = int'($urandom_range(0, row + 2048)) - 2048;
            span_end = int'($urandom_range(0, row + 2047)) - 2048;
        end
        else if (pick == 8)
        begin
            // Empty span that starts at or above the row.
            span_start = row - int'($urandom_range(0, 40));
            span_end = span_start - int'($urandom_range(1, 40));
        end
        else
        begin
            span_start = $urandom_range(0, 4095);
            span_end = $urandom_range(0, 4095);
        end

        pick = $urandom_range(0, 4);
        if (pick <= 1)
            distance = $urandom_range(0, 7400);
        else if (pick == 2)
            distance = $urandom_range(7300, 7450);
        else
            distance = $urandom_range(0, 65535);

        return make_req($urandom_range(0, 1023), row, span_start, span_end,
                        $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                        distance);
    endfunction

    // Drives one register write on the port; the shadow copy follows at once
    // since nothing is in flight while we write.
    task automatic write_reg(input cfg_idx_t idx, input logic [COLOR_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_WALL_A: palette.wall_a = value;
            CFG_WALL_B: palette.wall_b = value;
            CFG_WALL_C: palette.wall_c = value;
            CFG_WALL_D: palette.wall_d = value;
            CFG_SKY:    palette.sky = value;
            CFG_GROUND: palette.ground = value;
            CFG_HEIGHT: palette.height = value[HEIGHT_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic load_settings(input int height, input palette_t kind);
        logic [COLOR_W-1:0] high_side;
        logic [COLOR_W-1:0] low_side;
        high_side = (kind == PALETTE_HIGH_LOW) ? 24'hFFFFFF : 24'h000000;
        low_side = ~high_side;
        if (kind == PALETTE_RANDOM)
        begin
            write_reg(CFG_WALL_A, COLOR_W'($urandom));
            write_reg(CFG_WALL_B, COLOR_W'($urandom));
            write_reg(CFG_WALL_C, COLOR_W'($urandom));
            write_reg(CFG_WALL_D, COLOR_W'($urandom));
            write_reg(CFG_SKY, COLOR_W'($urandom));
            write_reg(CFG_GROUND, COLOR_W'($urandom));
        end
        else
        begin
            write_reg(CFG_WALL_A, high_side);
            write_reg(CFG_WALL_B, low_side);
            write_reg(CFG_WALL_C, high_side);
            write_reg(CFG_WALL_D, low_side);
            write_reg(CFG_SKY, low_side);
            write_reg(CFG_GROUND, high_side);
        end
        write_reg(CFG_HEIGHT, COLOR_W'(height));
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // Waits until the sender has nothing left and every expected pixel has come
    // back. Sampled on the falling edge so that all updates of the rising edge
    // have settled. Every item yields a pixel, so a short margin is enough.
    task automatic drain();
        @(negedge clk);
        while (pending_items.size() != 0 || item_ch.valid || expected_pixels.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic run_batch(input int count);
        repeat (count)
            pending_items.push_back(random_pixel());
        drain();
    endtask

    // ------------------------------------------------------------------
    // Clock and cycle limit
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d items queued and %0d pixels outstanding",
                     $time, pending_items.size(), expected_pixels.size());
            $display("raycast_column_pixel_shader_unit verification failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Item driver: presents one beat at a time from the pending queue and
    // records the expected pixel at the edge where the beat is accepted.
    // Random gaps are inserted between beats unless the run is in its
    // calm final stretch.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_ch.valid <= 1'b0;
            item_ch.column <= '0;
            item_ch.row <= '0;
            item_ch.span_start <= '0;
            item_ch.span_end <= '0;
            item_ch.step_x_negative <= 1'b0;
            item_ch.step_y_negative <= 1'b0;
            item_ch.hit_side_one <= 1'b0;
            item_ch.wall_distance <= '0;
            src_gap = 0;
        end
        else
        begin
            if (item_ch.valid && item_ch.ready)
            begin
                expected_pixels.push_back(predict_pixel(on_wire));
                region_count[classify(on_wire)]++;
                items_sent++;
            end
            // A beat still waiting for ready stays on the wire untouched.
            if (!item_ch.valid || item_ch.ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    item_ch.valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    on_wire = pending_items.pop_front();
                    item_ch.valid <= 1'b1;
                    item_ch.column <= on_wire.column;
                    item_ch.row <= on_wire.row;
                    item_ch.span_start <= on_wire.span_start;
                    item_ch.span_end <= on_wire.span_end;
                    item_ch.step_x_negative <= on_wire.step_x_negative;
                    item_ch.step_y_negative <= on_wire.step_y_negative;
                    item_ch.hit_side_one <= on_wire.hit_side_one;
                    item_ch.wall_distance <= on_wire.wall_distance;
                    if (!calm && $urandom_range(0, 7) == 0)
                        src_gap = $urandom_range(1, 5);
                end
                else
                begin
                    item_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: compares every accepted result beat with the oldest
    // expected pixel, and throttles ready in random stall bursts.
    // ------------------------------------------------------------------

    always @(posedge clk or negedge rst_n)
    begin
        rcps_pix_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            sink_stall = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result beat, expected none, actual color %06h index %05h",
                             $time, result_ch.pixel_color, result_ch.pixel_index);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (result_ch.pixel_color !== want.color)
                    begin
                        mismatches++;
                        $display("%0t: pixel_color mismatch, expected %06h actual %06h (index %05h)",
                                 $time, want.color, result_ch.pixel_color, want.index);
                    end
                    if (result_ch.pixel_index !== want.index)
                    begin
                        mismatches++;
                        $display("%0t: pixel_index mismatch, expected %05h actual %05h",
                                 $time, want.index, result_ch.pixel_index);
                    end
                    pixels_checked++;
                end
            end
            if (sink_stall > 0)
            begin
                sink_stall--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (!calm && $urandom_range(0, 7) == 0)
                    sink_stall = $urandom_range(1, 5);
            end
        end
    end

    // ------------------------------------------------------------------
    // Test sequence. Every batch below is followed by a full drain, so the
    // sender pauses until all expected pixels have arrived before the
    // registers are rewritten for the next batch.
    // ------------------------------------------------------------------

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.column = '0;
        item_ch.row = '0;
        item_ch.span_start = '0;
        item_ch.span_end = '0;
        item_ch.step_x_negative = 1'b0;
        item_ch.step_y_negative = 1'b0;
        item_ch.hit_side_one = 1'b0;
        item_ch.wall_distance = '0;
        result_ch.ready = 1'b0;
        calm = 1'b0;

        // Registers come out of reset black with a 768-row screen.
        palette = '0;
        palette.height = HEIGHT_RESET;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass: a distinct color per wall register so that a wrong wall
        // selection shows up at once.
        write_reg(CFG_WALL_A, 24'hFFFFFF);
        write_reg(CFG_WALL_B, 24'h123456);
        write_reg(CFG_WALL_C, 24'h80FF01);
        write_reg(CFG_WALL_D, 24'h00A5FF);
        write_reg(CFG_SKY, 24'h87CEEB);
        write_reg(CFG_GROUND, 24'hFFFFFF);
        write_reg(CFG_HEIGHT, 24'd768);
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_loaded++;

        // Sky above the span, including the very first and very last pixel.
        pending_items.push_back(make_req(0, 0, 1, 500, 0, 0, 0, 0));
        pending_items.push_back(make_req(1023, 1023, 2047, 2047, 1, 1, 1, 65535));
        pending_items.push_back(make_req(17, 199, 200, 400, 0, 1, 0, 100));
        // Each of the four wall colors, with unshaded, capped and near-cap distances.
        pending_items.push_back(make_req(5, 100, -2048, 2047, 0, 1, 1, 0));
        pending_items.push_back(make_req(6, 100, -2048, 2047, 1, 0, 1, 65535));
        pending_items.push_back(make_req(7, 100, 0, 300, 1, 0, 0, 7372));
        pending_items.push_back(make_req(8, 100, 0, 300, 0, 0, 0, 7373));
        pending_items.push_back(make_req(9, 100, 0, 300, 0, 1, 0, 16'h0100));
        // One-row span and the span edge at row zero.
        pending_items.push_back(make_req(10, 250, 250, 250, 1, 1, 0, 1));
        pending_items.push_back(make_req(11, 0, 0, 0, 0, 0, 1, 2048));
        // Ground below the span, down to the last row on screen.
        pending_items.push_back(make_req(12, 700, 0, 699, 0, 0, 0, 0));
        pending_items.push_back(make_req(13, 767, 0, 500, 1, 1, 1, 0));
        pending_items.push_back(make_req(14, 5, -2048, -2048, 0, 0, 0, 0));
        pending_items.push_back(make_req(15, 0, -1, -1, 0, 0, 0, 0));
        // Rows at and past the screen height fall back to ground shading.
        pending_items.push_back(make_req(16, 768, 0, 1000, 0, 0, 1, 0));
        pending_items.push_back(make_req(17, 800, 0, 2047, 1, 0, 0, 10));
        pending_items.push_back(make_req(18, 1023, -2048, 2047, 0, 1, 1, 10));
        // Empty spans.
        pending_items.push_back(make_req(19, 300, 300, 299, 0, 0, 0, 0));
        pending_items.push_back(make_req(20, 400, 300, 100, 1, 1, 1, 0));
        drain();

        // Random batches across a range of screen heights, including the
        // degenerate zero height and a height beyond the frame buffer.
        load_settings(1024, PALETTE_RANDOM);
        run_batch(90);
        load_settings(1, PALETTE_HIGH_LOW);
        run_batch(60);
        load_settings(0, PALETTE_LOW_HIGH);
        run_batch(50);
        load_settings(2047, PALETTE_HIGH_LOW);
        run_batch(50);
        load_settings($urandom_range(1, 1024), PALETTE_RANDOM);
        run_batch(90);

        // Final stretch with both sides running flat out.
        calm = 1'b1;
        load_settings($urandom_range(1, 1024), PALETTE_RANDOM);
        run_batch(150);

        repeat (10) @(posedge clk);

        $display("Sent %0d pixels and checked %0d results: %0d sky, %0d wall, %0d ground.",
                 items_sent, pixels_checked, region_count[REGION_SKY],
                 region_count[REGION_WALL], region_count[REGION_GROUND]);
        $display("Used %0d register settings with screen heights of 0, 1, 768, 1024, 2047 and random.",
                 settings_loaded);
        if (mismatches == 0)
            $display("raycast_column_pixel_shader_unit verification clean");
        else
            $display("raycast_column_pixel_shader_unit verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
sv/rcps_pkg.sv
sv/rcps_if.sv
sv/rcps_classify.sv
sv/rcps_factor.sv
sv/rcps_shade.sv
sv/raycast_column_pixel_shader_unit.sv
tb/raycast_column_pixel_shader_unit_test.sv
